// File: rtl/core/mmrr_pkg.sv
// Shared widths, constants and pipeline types for the MUSCL row reconstruction unit.
`timescale 1ns / 1ps

package mmrr_pkg;

	// Field widths of the sample and result items.
	localparam int SAMPLE_W = 32;
	localparam int COL_W    = 10;
	localparam int CFG_W    = 11;

	// Divider geometry: the quotient saturates at two to the power QUO_BITS.
	localparam int QUO_BITS = 34;
	localparam int DVSR_W   = 34;
	localparam int PROD_W   = 66;
	localparam int REM_W    = DVSR_W + QUO_BITS;

	localparam logic signed [SAMPLE_W-1:0] RES_MAX = 32'sh7FFF_FFFF;
	localparam logic signed [SAMPLE_W-1:0] RES_MIN = 32'sh8000_0000;

	// Side data that rides along with an item through the arithmetic stages.
	typedef struct packed {
		logic signed [SAMPLE_W-1:0] vc;
		logic [COL_W-1:0]           col;
		logic                       last;
	} tag_t;

	// One stage of the restoring divider.
	typedef struct packed {
		logic [REM_W-1:0]    rem;
		logic [QUO_BITS-1:0] quo;
		logic [DVSR_W-1:0]   dvsr;
		logic                neg;
		logic                ovf;
		logic                zero;
		tag_t                tag;
	} dv_t;

	// One line buffer entry: rows above and centre for depth and velocity.
	typedef struct packed {
		logic [SAMPLE_W-1:0] h_above;
		logic [SAMPLE_W-1:0] h_centre;
		logic [SAMPLE_W-1:0] v_above;
		logic [SAMPLE_W-1:0] v_centre;
	} line_word_t;

endpackage

// File: rtl/core/mmrr_if.sv
// Valid/ready stream interfaces for the sample and result items.
`timescale 1ns / 1ps

interface mmrr_sample_if import mmrr_pkg::*; ();
	logic                valid;
	logic                ready;
	logic                start_of_frame;
	logic [SAMPLE_W-1:0] depth_sample;
	logic [SAMPLE_W-1:0] velocity_sample;

	modport source (output valid, start_of_frame, depth_sample, velocity_sample, input ready);
	modport sink (input valid, start_of_frame, depth_sample, velocity_sample, output ready);
endinterface

interface mmrr_result_if import mmrr_pkg::*; ();
	logic                valid;
	logic                ready;
	logic [SAMPLE_W-1:0] reconstructed_velocity;
	logic [COL_W-1:0]    column_index;
	logic                row_end;
	logic                zero_depth;
	logic                saturated;

	modport source (output valid, reconstructed_velocity, column_index, row_end, zero_depth,
		saturated, input ready);
	modport sink (input valid, reconstructed_velocity, column_index, row_end, zero_depth,
		saturated, output ready);
endinterface

// File: rtl/core/muscl_minmod_row_reconstruct_unit.sv
// Top level: line buffers, minmod slopes, multiplier and pipelined divider.
// Items pass stage 1, stages 2 to 7, the divider and the final sum into the output register.
// Throughput: one item per cycle; the whole pipeline advances when the output is free or taken.
// The divider resolves one quotient bit per stage over 34 stages, which sets the depth.
// Reset clears all valid bits, the column and row counts, and sets row_width to 1024.
// The line buffers are not cleared; rows fill them before they are read.
`timescale 1ns / 1ps

module muscl_minmod_row_reconstruct_unit import mmrr_pkg::*; #(
	parameter int unsigned MAX_WIDTH = 1024
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               row_width_we,
	input  logic [CFG_W-1:0]   row_width_wdata,
	mmrr_sample_if.sink        sample_in,
	mmrr_result_if.source      result_out
);

	localparam int CW = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
	localparam int WW = CW + 1;

	function automatic logic signed [32:0] minmod(input logic signed [32:0] a,
		input logic signed [32:0] b);
		logic signed [32:0] r;
		begin
			if (!a[32] && !b[32]) begin
				r = (a < b) ? a : b;
			end else if ((a[32] || a == 0) && (b[32] || b == 0)) begin
				r = (a > b) ? a : b;
			end else begin
				r = '0;
			end
			return r;
		end
	endfunction

	logic en;
	logic accept;

	// Configuration and frame position.
	logic [CFG_W-1:0] row_width_q;
	logic [CW-1:0]    col_count_q;
	logic [1:0]       rows_seen_q;

	logic [WW-1:0] width_eff;
	logic [CW-1:0] last_col;
	logic [CW-1:0] col_cur;
	logic [CW-1:0] col_sel;
	logic [1:0]    rows_cur;
	logic          at_end;

	// Stage 1: line buffer read.
	line_word_t          line_mem [MAX_WIDTH];
	line_word_t          rd_s1;
	line_word_t          fwd_word_s1;
	line_word_t          eff_s1;
	line_word_t          wr_word;
	logic                fwd_s1;
	logic                v_s1;
	logic                emit_s1;
	logic                last_s1;
	logic [CW-1:0]       col_s1;
	logic [SAMPLE_W-1:0] hb_s1;
	logic [SAMPLE_W-1:0] vb_s1;

	// Stages 2 to 7: slopes, numerator, product.
	logic                     v_s2, v_s3, v_s4, v_s5, v_s6, v_s7;
	tag_t                     tag_s2, tag_s3, tag_s4, tag_s5, tag_s6, tag_s7;
	logic signed [32:0]       d1h_s2, d2h_s2, d1v_s2, d2v_s2;
	logic signed [31:0]       hc_s2, hc_s3;
	logic signed [32:0]       mh_s3, mv_s3;
	logic                     zero_s3, zero_s4, zero_s5, zero_s6, zero_s7;
	logic signed [34:0]       num2_s4;
	logic [31:0]              mvmag_s4, mvmag_s5;
	logic                     mvneg_s4, hcneg_s4;
	logic [31:0]              hcmag_s4;
	logic [33:0]              n2mag_s5;
	logic                     neg_s5, neg_s6, neg_s7;
	logic [DVSR_W-1:0]        dvsr_s5, dvsr_s6, dvsr_s7;
	logic [48:0]              pl_s6, ph_s6;
	logic [PROD_W-1:0]        p_s7;

	// Divider stages; entry zero holds the saturation check.
	dv_t                 dv_s [QUO_BITS+1];
	logic [QUO_BITS:0]   dv_v_s;

	// Final sum and output register.
	logic               v_s43;
	logic signed [35:0] sum_s43;
	logic               ovf_s43, neg_s43, zero_s43;
	tag_t               tag_s43;

	logic               out_valid_q;
	logic [SAMPLE_W-1:0] res_q;
	logic [COL_W-1:0]   col_q;
	logic               last_q, zero_q, sat_q;
	logic [SAMPLE_W-1:0] res_d;
	logic               sat_d;

	// Pipeline enable: advance whenever the output register can move.
	assign en     = !out_valid_q || result_out.ready;
	assign accept = sample_in.valid && en;
	assign sample_in.ready = en;

	// Configuration register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_width_q <= CFG_W'(1024);
		end else if (row_width_we) begin
			row_width_q <= row_width_wdata;
		end
	end

	// Effective row width and column selection.
	always_comb begin
		if (row_width_q < CFG_W'(3)) begin
			width_eff = WW'(3);
		end else if (32'(row_width_q) > 32'(MAX_WIDTH)) begin
			width_eff = WW'(MAX_WIDTH);
		end else begin
			width_eff = WW'(row_width_q);
		end
		last_col = CW'(width_eff - WW'(1));
		col_cur  = sample_in.start_of_frame ? '0 : col_count_q;
		rows_cur = sample_in.start_of_frame ? 2'd0 : rows_seen_q;
		at_end   = col_cur >= last_col;
		col_sel  = at_end ? last_col : col_cur;
	end

	// Column and row counters.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_count_q <= '0;
			rows_seen_q <= 2'd0;
		end else if (accept) begin
			col_count_q <= at_end ? '0 : CW'(col_sel + CW'(1));
			if (at_end && rows_cur != 2'd2) begin
				rows_seen_q <= rows_cur + 2'd1;
			end else begin
				rows_seen_q <= rows_cur;
			end
		end
	end

	// Forwarding covers an item that reads the entry the previous item writes.
	assign eff_s1  = fwd_s1 ? fwd_word_s1 : rd_s1;
	assign wr_word = '{h_above: eff_s1.h_centre, h_centre: hb_s1,
		v_above: eff_s1.v_centre, v_centre: vb_s1};

	// Line buffer: the centre row moves to the row above as the new sample lands.
	always_ff @(posedge clk) begin
		if (en) begin
			rd_s1 <= line_mem[col_sel];
			if (v_s1) begin
				line_mem[col_s1] <= wr_word;
			end
		end
	end

	// Stage 1 registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1   <= 1'b0;
			fwd_s1 <= 1'b0;
		end else if (en) begin
			v_s1   <= accept;
			fwd_s1 <= v_s1 && (col_s1 == col_sel);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			fwd_word_s1 <= wr_word;
			emit_s1     <= rows_cur == 2'd2;
			last_s1     <= at_end;
			col_s1      <= col_sel;
			hb_s1       <= sample_in.depth_sample;
			vb_s1       <= sample_in.velocity_sample;
		end
	end

	// Valid bits of the arithmetic stages; items of the first two rows drop out here.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
			v_s6 <= 1'b0;
			v_s7 <= 1'b0;
		end else if (en) begin
			v_s2 <= v_s1 && emit_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
			v_s6 <= v_s5;
			v_s7 <= v_s6;
		end
	end

	// Stages 2 to 7 payload.
	always_ff @(posedge clk) begin
		if (en) begin
			// Row differences.
			d1h_s2 <= {eff_s1.h_centre[31], eff_s1.h_centre} - {hb_s1[31], hb_s1};
			d2h_s2 <= {eff_s1.h_above[31], eff_s1.h_above} - {eff_s1.h_centre[31], eff_s1.h_centre};
			d1v_s2 <= {eff_s1.v_centre[31], eff_s1.v_centre} - {vb_s1[31], vb_s1};
			d2v_s2 <= {eff_s1.v_above[31], eff_s1.v_above} - {eff_s1.v_centre[31], eff_s1.v_centre};
			hc_s2  <= eff_s1.h_centre;
			tag_s2 <= '{vc: eff_s1.v_centre, col: COL_W'(col_s1), last: last_s1};

			// Limited slopes.
			mh_s3   <= minmod(d1h_s2, d2h_s2);
			mv_s3   <= minmod(d1v_s2, d2v_s2);
			zero_s3 <= hc_s2 == '0;
			hc_s3   <= hc_s2;
			tag_s3  <= tag_s2;

			// Numerator 2h - mh and magnitudes.
			num2_s4  <= {{2{hc_s3[31]}}, hc_s3, 1'b0} - {{2{mh_s3[32]}}, mh_s3};
			mvmag_s4 <= mv_s3[32] ? 32'(-mv_s3) : 32'(mv_s3);
			mvneg_s4 <= mv_s3[32];
			hcneg_s4 <= hc_s3[31];
			hcmag_s4 <= hc_s3[31] ? 32'(-hc_s3) : 32'(hc_s3);
			zero_s4  <= zero_s3;
			tag_s4   <= tag_s3;

			// Sign of the quotient and divisor 4|h|.
			n2mag_s5 <= num2_s4[34] ? 34'(-num2_s4) : 34'(num2_s4);
			neg_s5   <= (mvneg_s4 != num2_s4[34]) != hcneg_s4;
			mvmag_s5 <= mvmag_s4;
			dvsr_s5  <= {hcmag_s4, 2'b00};
			zero_s5  <= zero_s4;
			tag_s5   <= tag_s4;

			// Two partial products.
			pl_s6   <= 49'(mvmag_s5) * 49'(n2mag_s5[16:0]);
			ph_s6   <= 49'(mvmag_s5) * 49'(n2mag_s5[33:17]);
			neg_s6  <= neg_s5;
			dvsr_s6 <= dvsr_s5;
			zero_s6 <= zero_s5;
			tag_s6  <= tag_s5;

			// Full product.
			p_s7    <= PROD_W'(pl_s6) + (PROD_W'(ph_s6) << 17);
			neg_s7  <= neg_s6;
			dvsr_s7 <= dvsr_s6;
			zero_s7 <= zero_s6;
			tag_s7  <= tag_s6;
		end
	end

	// Divider entry: a quotient of two to the QUO_BITS or more saturates.
	always_ff @(posedge clk) begin
		if (en) begin
			dv_s[0].rem  <= REM_W'(p_s7);
			dv_s[0].quo  <= '0;
			dv_s[0].dvsr <= dvsr_s7;
			dv_s[0].neg  <= neg_s7;
			dv_s[0].ovf  <= REM_W'(p_s7) >= {dvsr_s7, {QUO_BITS{1'b0}}};
			dv_s[0].zero <= zero_s7;
			dv_s[0].tag  <= tag_s7;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dv_v_s <= '0;
		end else if (en) begin
			dv_v_s <= {dv_v_s[QUO_BITS-1:0], v_s7};
		end
	end

	// Restoring divider, one quotient bit per stage from the top bit down.
	for (genvar j = 1; j <= QUO_BITS; j++) begin : g_div
		localparam int K = QUO_BITS - j;
		dv_t              nxt;
		logic [REM_W-1:0] trial;

		always_comb begin
			nxt   = dv_s[j-1];
			trial = REM_W'(nxt.dvsr) << K;
			if (nxt.rem >= trial) begin
				nxt.rem    = nxt.rem - trial;
				nxt.quo[K] = 1'b1;
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				dv_s[j] <= nxt;
			end
		end
	end

	// Signed quotient added to the centre velocity.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s43 <= 1'b0;
		end else if (en) begin
			v_s43 <= dv_v_s[QUO_BITS];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sum_s43 <= 36'(dv_s[QUO_BITS].tag.vc) + (dv_s[QUO_BITS].neg ?
				-$signed({2'b00, dv_s[QUO_BITS].quo}) : $signed({2'b00, dv_s[QUO_BITS].quo}));
			ovf_s43  <= dv_s[QUO_BITS].ovf;
			neg_s43  <= dv_s[QUO_BITS].neg;
			zero_s43 <= dv_s[QUO_BITS].zero;
			tag_s43  <= dv_s[QUO_BITS].tag;
		end
	end

	// Saturation and the zero depth pass-through.
	always_comb begin
		if (zero_s43) begin
			res_d = tag_s43.vc;
			sat_d = 1'b0;
		end else if (ovf_s43) begin
			res_d = neg_s43 ? RES_MIN : RES_MAX;
			sat_d = 1'b1;
		end else if (sum_s43 > 36'(RES_MAX)) begin
			res_d = RES_MAX;
			sat_d = 1'b1;
		end else if (sum_s43 < 36'(RES_MIN)) begin
			res_d = RES_MIN;
			sat_d = 1'b1;
		end else begin
			res_d = 32'(sum_s43);
			sat_d = 1'b0;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= v_s43;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_q  <= res_d;
			col_q  <= tag_s43.col;
			last_q <= tag_s43.last;
			zero_q <= zero_s43;
			sat_q  <= sat_d;
		end
	end

	assign result_out.valid                  = out_valid_q;
	assign result_out.reconstructed_velocity = res_q;
	assign result_out.column_index           = col_q;
	assign result_out.row_end                = last_q;
	assign result_out.zero_depth             = zero_q;
	assign result_out.saturated              = sat_q;

endmodule

// File: rtl/core/mmrr_checker.sv
// Port-level assertions for the MUSCL row reconstruction unit and their bind.
`timescale 1ns / 1ps

module mmrr_checker import mmrr_pkg::*; (
	input logic                clk,
	input logic                arst_n,
	input logic                in_ready,
	input logic                out_valid,
	input logic                out_ready,
	input logic [SAMPLE_W-1:0] out_velocity,
	input logic                out_zero,
	input logic                out_sat
);

	// A stalled result item stays put.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(out_velocity))
		else $error("result item changed while stalled");

	// An empty output register never blocks the input.
	a_ready: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with an empty output register");

	// A zero depth result is passed through and never clipped.
	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_zero |-> !out_sat)
		else $error("zero depth result flagged as saturated");

	// A clipped result sits on one end of the range.
	a_sat: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_sat |-> out_velocity == RES_MAX || out_velocity == RES_MIN)
		else $error("saturated result not at a range limit");

endmodule

bind muscl_minmod_row_reconstruct_unit mmrr_checker u_mmrr_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_ready     (sample_in.ready),
	.out_valid    (result_out.valid),
	.out_ready    (result_out.ready),
	.out_velocity (result_out.reconstructed_velocity),
	.out_zero     (result_out.zero_depth),
	.out_sat      (result_out.saturated)
);

// File: tb/tb.sv
// Self-checking testbench for the MUSCL minmod row reconstruction unit.
`timescale 1ns / 1ps

module tb;
	import mmrr_pkg::*;

	// One sample item with an optional typed expectation.
	typedef struct {
		bit                  sof;
		logic [SAMPLE_W-1:0] h;
		logic [SAMPLE_W-1:0] v;
		bit                  typed;
		logic [SAMPLE_W-1:0] ev;
		logic [COL_W-1:0]    ec;
		bit                  ee;
		bit                  ez;
		bit                  es;
	} stim_row_t;

	// One reconstructed velocity item.
	typedef struct {
		logic [SAMPLE_W-1:0] vel;
		logic [COL_W-1:0]    col;
		bit                  row_end;
		bit                  zero;
		bit                  sat;
	} recon_t;

	localparam int MAXW     = 1024;
	localparam int DIR_ROWS = 18;

	logic clk;
	logic arst_n;
	logic row_width_we;
	logic [CFG_W-1:0] row_width_wdata;

	mmrr_sample_if s_if ();
	mmrr_result_if r_if ();

	muscl_minmod_row_reconstruct_unit u_top (
		.clk            (clk),
		.arst_n         (arst_n),
		.row_width_we   (row_width_we),
		.row_width_wdata(row_width_wdata),
		.sample_in      (s_if),
		.result_out     (r_if)
	);

	// Shadow line buffers and counters of the block.
	logic signed [SAMPLE_W-1:0] h_above [MAXW];
	logic signed [SAMPLE_W-1:0] h_centre [MAXW];
	logic signed [SAMPLE_W-1:0] v_above [MAXW];
	logic signed [SAMPLE_W-1:0] v_centre [MAXW];
	int unsigned col_count;
	int unsigned rows_done;
	int unsigned width_reg;

	recon_t expected_q [$];
	stim_row_t dir_tab [DIR_ROWS];
	int n_items;
	int n_results;
	int n_fail;
	bit quiet;
	int hold_req;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("CHECK FAILED");
		$finish;
	end

	function automatic logic [63:0] magn(input longint x);
		return (x < 0) ? 64'(-x) : 64'(x);
	endfunction

	function automatic longint minmod(input longint a, input longint b);
		if (a >= 0 && b >= 0) return (a < b) ? a : b;
		if (a <= 0 && b <= 0) return (a > b) ? a : b;
		return 0;
	endfunction

	// Updates the shadow state with one accepted sample and returns its result, if any.
	function automatic bit reconstruct(input bit sof, input logic [31:0] hb,
			input logic [31:0] vb, output recon_t r);
		int unsigned w;
		int unsigned c;
		bit last;
		bit has;
		longint ha, hc, va, vc, h1, v1, mh, mv, num2, res;
		logic [127:0] prod, quo;
		bit neg;
		w = (width_reg < 3) ? 3 : (width_reg > MAXW) ? MAXW : width_reg;
		if (sof) begin
			col_count = 0;
			rows_done = 0;
		end
		c = (col_count >= w) ? w - 1 : col_count;
		last = (c == w - 1);
		has = (rows_done >= 2);
		r = '{default: '0};
		if (has) begin
			ha = h_above[c];
			hc = h_centre[c];
			va = v_above[c];
			vc = v_centre[c];
			h1 = longint'($signed(hb));
			v1 = longint'($signed(vb));
			res = vc;
			if (hc == 0) begin
				r.zero = 1'b1;
			end else begin
				mh = minmod(hc - h1, ha - hc);
				mv = minmod(vc - v1, va - vc);
				num2 = 2 * hc - mh;
				neg = ((mv < 0) != (num2 < 0)) != (hc < 0);
				prod = {64'd0, magn(mv)} * {64'd0, magn(num2)};
				quo = prod / {64'd0, magn(hc) * 4};
				if (mv == 0 || num2 == 0) quo = '0;
				if (quo >= (128'd1 << 34)) begin
					r.sat = 1'b1;
					res = neg ? -64'sd2147483648 : 64'sd2147483647;
				end else begin
					res = vc + (neg ? -longint'(quo[63:0]) : longint'(quo[63:0]));
					if (res > 64'sd2147483647) begin
						res = 64'sd2147483647;
						r.sat = 1'b1;
					end
					if (res < -64'sd2147483648) begin
						res = -64'sd2147483648;
						r.sat = 1'b1;
					end
				end
			end
			r.vel = res[31:0];
			r.col = c[COL_W-1:0];
			r.row_end = last;
		end
		h_above[c] = h_centre[c];
		v_above[c] = v_centre[c];
		h_centre[c] = hb;
		v_centre[c] = vb;
		if (last) begin
			col_count = 0;
			if (rows_done < 2) rows_done++;
		end else begin
			col_count = c + 1;
		end
		return has;
	endfunction

	// Offers one sample item, waits for acceptance and records its expectation.
	task automatic send_sample(input stim_row_t s);
		int gap;
		recon_t r;
		bit has;
		gap = 0;
		if (!quiet && $urandom_range(0, 3) == 0)
			gap = ($urandom_range(0, 15) == 0) ? $urandom_range(10, 40) : $urandom_range(1, 3);
		if (gap > 0) begin
			s_if.valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_if.valid <= 1'b1;
		s_if.start_of_frame <= s.sof;
		s_if.depth_sample <= s.h;
		s_if.velocity_sample <= s.v;
		@(posedge clk);
		while (!s_if.ready) @(posedge clk);
		n_items++;
		has = reconstruct(s.sof, s.h, s.v, r);
		if (s.typed) begin
			r.vel = s.ev;
			r.col = s.ec;
			r.row_end = s.ee;
			r.zero = s.ez;
			r.sat = s.es;
		end
		if (has) expected_q.push_back(r);
	endtask

	task automatic wait_drained();
		s_if.valid <= 1'b0;
		while (expected_q.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	// Writes row_width while the block is idle.
	task automatic set_width(input int unsigned w);
		wait_drained();
		row_width_we <= 1'b1;
		row_width_wdata <= w[CFG_W-1:0];
		@(posedge clk);
		row_width_we <= 1'b0;
		width_reg = w;
	endtask

	function automatic logic [31:0] rand_sample();
		case ($urandom_range(0, 9))
			0: return $urandom;
			1: begin
				case ($urandom_range(0, 4))
					0: return 32'h8000_0000;
					1: return 32'h7FFF_FFFF;
					2: return 32'h0000_0001;
					3: return 32'hFFFF_FFFF;
					default: return 32'h0;
				endcase
			end
			2: return 32'h0;
			default: return 32'($signed($urandom_range(0, 2097152)) - 1048576);
		endcase
	endfunction

	// Result checker and ready generator.
	initial begin
		recon_t e;
		int stall;
		stall = 0;
		r_if.ready <= 1'b0;
		forever begin
			@(posedge clk);
			if (r_if.valid && r_if.ready) begin
				n_results++;
				if (expected_q.size() == 0) begin
					$error("result item with no expectation, col %0d", r_if.column_index);
					n_fail++;
				end else begin
					e = expected_q.pop_front();
					if (r_if.reconstructed_velocity !== e.vel) begin
						$error("reconstructed_velocity: expected %h actual %h", e.vel,
							r_if.reconstructed_velocity);
						n_fail++;
					end
					if (r_if.column_index !== e.col) begin
						$error("column_index: expected %0d actual %0d", e.col, r_if.column_index);
						n_fail++;
					end
					if (r_if.row_end !== e.row_end) begin
						$error("row_end: expected %0d actual %0d", e.row_end, r_if.row_end);
						n_fail++;
					end
					if (r_if.zero_depth !== e.zero) begin
						$error("zero_depth: expected %0d actual %0d", e.zero, r_if.zero_depth);
						n_fail++;
					end
					if (r_if.saturated !== e.sat) begin
						$error("saturated: expected %0d actual %0d", e.sat, r_if.saturated);
						n_fail++;
					end
				end
			end
			if (hold_req > 0) begin
				r_if.ready <= 1'b0;
				hold_req--;
			end else if (stall > 0) begin
				r_if.ready <= 1'b0;
				stall--;
			end else begin
				r_if.ready <= 1'b1;
				if (!quiet && $urandom_range(0, 3) == 0)
					stall = ($urandom_range(0, 19) == 0) ? $urandom_range(20, 60)
						: $urandom_range(1, 3);
			end
		end
	end

	// Main sequence: reset, directed table, then random phases.
	initial begin
		int unsigned widths [12];
		int unsigned w, ew, rows, n_send;
		stim_row_t s;
		n_items = 0;
		n_results = 0;
		n_fail = 0;
		quiet = 1'b0;
		hold_req = 0;
		col_count = 0;
		rows_done = 0;
		width_reg = 1024;
		for (int i = 0; i < MAXW; i++) begin
			h_above[i] = '0;
			h_centre[i] = '0;
			v_above[i] = '0;
			v_centre[i] = '0;
		end
		arst_n <= 1'b0;
		row_width_we <= 1'b0;
		row_width_wdata <= '0;
		s_if.valid <= 1'b0;
		s_if.start_of_frame <= 1'b0;
		s_if.depth_sample <= '0;
		s_if.velocity_sample <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Width 3: zero centre depth, both saturation signs, then mixed rows.
		dir_tab = '{
			'{1, 32'd5, 32'd7, 0, 0, 0, 0, 0, 0},
			'{0, 32'h8000_0000, 32'h7FFF_FFFF, 0, 0, 0, 0, 0, 0},
			'{0, 32'h8000_0000, 32'h8000_0000, 0, 0, 0, 0, 0, 0},
			'{0, 32'h0, 32'h0001_2345, 0, 0, 0, 0, 0, 0},
			'{0, 32'h1, 32'h0, 0, 0, 0, 0, 0, 0},
			'{0, 32'h1, 32'h0, 0, 0, 0, 0, 0, 0},
			'{0, 32'd9, 32'd3, 1, 32'h0001_2345, 10'd0, 0, 1, 0},
			'{0, 32'h7FFF_FFFF, 32'h8000_0000, 1, 32'h7FFF_FFFF, 10'd1, 0, 0, 1},
			'{0, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1, 32'h8000_0000, 10'd2, 1, 0, 1},
			'{0, 32'd100, 32'd50, 0, 0, 0, 0, 0, 0},
			'{0, 32'h0001_0000, 32'hFFFF_0000, 0, 0, 0, 0, 0, 0},
			'{0, 32'hFFFF_FFFF, 32'h1, 0, 0, 0, 0, 0, 0},
			'{0, 32'hFFFF_FFFB, 32'd2, 0, 0, 0, 0, 0, 0},
			'{0, 32'd3, 32'd3, 0, 0, 0, 0, 0, 0},
			'{0, 32'h0, 32'h0, 0, 0, 0, 0, 0, 0},
			'{1, 32'd2, 32'd2, 0, 0, 0, 0, 0, 0},
			'{0, 32'h0002_0000, 32'h0003_0000, 0, 0, 0, 0, 0, 0},
			'{0, 32'h5555_5555, 32'hAAAA_AAAA, 0, 0, 0, 0, 0, 0}
		};
		set_width(3);
		foreach (dir_tab[i]) send_sample(dir_tab[i]);

		// Random phases, each opening a new frame except the mid-row shrink.
		widths = '{4, 0, 16, 2, 5, 33, 7, 40, 5, 2047, 3, 100};
		for (int p = 0; p < 12; p++) begin
			w = widths[p];
			ew = (w < 3) ? 3 : (w > MAXW) ? MAXW : w;
			set_width(w);
			quiet = (p == 4);
			if (p == 8) begin
				rows = 40;
				for (int k = 0; k < rows; k++) begin
					s = '{0, rand_sample(), rand_sample(), 0, 0, 0, 0, 0, 0};
					send_sample(s);
				end
				continue;
			end
			// The widest rows only get into their third row; phase 7 stops mid-row.
			rows = 40 / ew + 3;
			n_send = (ew >= MAXW) ? 2 * ew + 100 : rows * ew + ((p == 7) ? 20 : 0);
			for (int k = 0; k < n_send; k++) begin
				s = '{(k == 0) || ($urandom_range(0, 199) == 0), rand_sample(), rand_sample(),
					0, 0, 0, 0, 0, 0};
				if (p == 2 && k == 60) hold_req = 400;
				if (p == 5 && k == 100) begin
					s_if.valid <= 1'b0;
					while (expected_q.size() != 0) @(posedge clk);
				end
				send_sample(s);
			end
		end
		quiet = 1'b0;
		wait_drained();
		$display("Sent %0d sample items over 13 row_width settings, checked %0d results.",
			n_items, n_results);
		$display("Covered zero depth, saturation, clamped widths and a mid-row width shrink.");
		if (n_fail == 0) begin
			$display("CHECK OK");
		end else begin
			$display("CHECK FAILED");
		end
		$finish;
	end

endmodule
